[design/alsl_pkg.sv]
// Package: shared constants, codes and controller/datapath link types.
package alsl_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int LEN_W        = 32;
    localparam int SUM_W        = 40;
    localparam int POS_W        = 40;
    localparam int REM_W        = 41;
    localparam int TOL_W        = 16;
    localparam int SIDX_W       = 8;
    localparam int CODE_W       = 2;

    typedef enum logic [CODE_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_LOCATE = 2'd2
    } t_func;

    typedef enum logic [CODE_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the accepted item
        logic simple;    // finish clear, append, empty locate or unused code
        logic key_init;  // clamp the position and open the search window
        logic rd_mid;    // read the sum at the window midpoint
        logic step;      // narrow the window on the read sum
        logic fix;       // clamp the found index and read the sum before it
        logic rem_calc;  // form the remainder
        logic publish;   // move the result into the output register
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_locate;
        logic empty;
        logic search_go;
        logic out_free;
    } t_dp_stat;

endpackage

[design/alsl_ifs.sv]
// Interfaces: item, result and configuration channels.
interface alsl_item_if;
    import alsl_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CODE_W-1:0]       func;
    logic [LEN_W-1:0]        segment_length;
    logic signed [POS_W-1:0] position;

    modport source (output valid, func, segment_length, position, input ready);
    modport sink   (input valid, func, segment_length, position, output ready);
endinterface

interface alsl_result_if;
    import alsl_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [SIDX_W-1:0]       segment_index;
    logic signed [REM_W-1:0] remainder;
    logic [CODE_W-1:0]       status;

    modport source (output valid, segment_index, remainder, status, input ready);
    modport sink   (input valid, segment_index, remainder, status, output ready);
endinterface

interface alsl_cfg_if;
    import alsl_pkg::*;
    logic             valid;
    logic             ready;
    logic [TOL_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[design/alsl_ctrl.sv]
// Controller: sequences decode, binary search, remainder and result hand-off.
module alsl_ctrl
    import alsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DECODE  = 7'b0000010,
        S_PROBE   = 7'b0000100,
        S_COMPARE = 7'b0001000,
        S_FIX     = 7'b0010000,
        S_REMAIN  = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_locate && !i_stat.empty) begin
                    o_cmd.key_init = 1'b1;
                    n_state        = S_PROBE;
                end else begin
                    o_cmd.simple = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_PROBE: begin
                if (i_stat.search_go) begin
                    o_cmd.rd_mid = 1'b1;
                    n_state      = S_COMPARE;
                end else begin
                    o_cmd.fix = 1'b1;
                    n_state   = S_FIX;
                end
            end
            S_COMPARE: begin
                o_cmd.step = 1'b1;
                n_state    = S_PROBE;
            end
            S_FIX: begin
                // read data for the preceding sum lands here
                n_state = S_REMAIN;
            end
            S_REMAIN: begin
                o_cmd.rem_calc = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/alsl_dpath.sv]
// Datapath: running-sum memory, clamp, search window, remainder and output register.
module alsl_dpath
    import alsl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic [CODE_W-1:0]        i_func,
    input  logic [LEN_W-1:0]         i_segment_length,
    input  logic signed [POS_W-1:0]  i_position,
    input  logic                     i_cfg_write,
    input  logic [TOL_W-1:0]         i_cfg_data,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [SIDX_W-1:0]        o_segment_index,
    output logic signed [REM_W-1:0]  o_remainder,
    output logic [CODE_W-1:0]        o_status
);

    logic [SUM_W-1:0]        mem [MAX_SEGMENTS];
    logic [SUM_W-1:0]        r_rdata;

    logic [CODE_W-1:0]       r_func;
    logic [LEN_W-1:0]        r_len;
    logic signed [POS_W-1:0] r_pos;
    logic [TOL_W-1:0]        r_tol;
    logic [CNT_W-1:0]        r_count;
    logic [SUM_W-1:0]        r_total;
    logic [SUM_W-1:0]        r_key;
    logic [CNT_W-1:0]        r_lo;
    logic [CNT_W-1:0]        r_hi;
    logic [CNT_W-1:0]        r_mid;

    logic [SIDX_W-1:0]       r_res_idx;
    logic signed [REM_W-1:0] r_res_rem;
    logic [CODE_W-1:0]       r_res_status;
    logic                    r_out_valid;

    logic                    n_full;
    logic [SUM_W:0]          n_raw_sum;
    logic [SUM_W-1:0]        n_sum;
    logic signed [SUM_W+1:0] n_s, n_tol, n_tot, n_diff, n_adiff, n_rem;
    logic [SUM_W-1:0]        n_key;
    logic [CNT_W-1:0]        n_mid, n_loc, n_prev;
    logic                    n_rd_en;
    logic [IDX_W-1:0]        n_rd_addr;
    logic                    n_wr_en;
    logic signed [REM_W-1:0] n_rem_sat;

    assign n_full = (r_count == CNT_W'(MAX_SEGMENTS));

    // append: saturate the new running sum at the top of the sum range
    assign n_raw_sum = {1'b0, ((r_count == '0) ? {SUM_W{1'b0}} : r_total)}
                     + (SUM_W+1)'(r_len);
    assign n_sum     = n_raw_sum[SUM_W] ? '1 : n_raw_sum[SUM_W-1:0];

    // clamp the position into [0, total] for the search key
    assign n_s     = (SUM_W+2)'(r_pos);
    assign n_tol   = (SUM_W+2)'(r_tol);
    assign n_tot   = (SUM_W+2)'(r_total);
    assign n_diff  = n_s - n_tot;
    assign n_adiff = n_diff[SUM_W+1] ? -n_diff : n_diff;

    always_comb begin
        if (n_s < 0 || n_s < n_tol) begin
            n_key = '0;
        end else if (n_s > n_tot || n_adiff < n_tol) begin
            n_key = r_total;
        end else begin
            n_key = r_pos[SUM_W-1:0];
        end
    end

    assign n_mid  = r_lo + ((r_hi - r_lo) >> 1);
    assign n_loc  = (r_lo >= r_count) ? (r_count - 1'b1) : r_lo;
    assign n_prev = n_loc - 1'b1;

    assign n_rem     = n_s - (SUM_W+2)'(r_rdata);
    assign n_rem_sat = (n_rem[SUM_W+1] != n_rem[SUM_W])
                     ? (n_rem[SUM_W+1] ? {1'b1, {(REM_W-1){1'b0}}}
                                       : {1'b0, {(REM_W-1){1'b1}}})
                     : n_rem[REM_W-1:0];

    assign n_rd_en   = i_cmd.rd_mid | i_cmd.fix;
    assign n_rd_addr = i_cmd.rd_mid ? n_mid[IDX_W-1:0] : n_prev[IDX_W-1:0];
    assign n_wr_en   = i_cmd.simple && (r_func == FUNC_APPEND) && !n_full;

    // single-port sum store: write on append, registered read for the search
    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            mem[r_count[IDX_W-1:0]] <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rd_en) begin
            r_rdata <= mem[n_rd_addr];
        end
    end

    // item capture, search window and result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_len  <= i_segment_length;
            r_pos  <= i_position;
        end
        if (i_cmd.simple) begin
            r_res_idx <= '0;
            r_res_rem <= '0;
            case (r_func)
                FUNC_APPEND: begin
                    if (n_full) begin
                        r_res_status <= STAT_FULL;
                    end else begin
                        r_res_status <= STAT_OK;
                        r_total      <= n_sum;
                    end
                end
                FUNC_LOCATE: begin
                    r_res_status <= STAT_EMPTY;
                end
                default: begin
                    r_res_status <= STAT_OK;
                end
            endcase
        end
        if (i_cmd.key_init) begin
            r_key <= n_key;
            r_lo  <= '0;
            r_hi  <= r_count;
        end
        if (i_cmd.rd_mid) begin
            r_mid <= n_mid;
        end
        if (i_cmd.step) begin
            if (r_rdata < r_key) begin
                r_lo <= r_mid + 1'b1;
            end else begin
                r_hi <= r_mid;
            end
        end
        if (i_cmd.fix) begin
            r_lo <= n_loc;
        end
        if (i_cmd.rem_calc) begin
            r_res_idx    <= SIDX_W'(r_lo);
            r_res_rem    <= (r_lo == '0) ? REM_W'(r_pos) : n_rem_sat;
            r_res_status <= STAT_OK;
        end
        if (i_cmd.publish) begin
            o_segment_index <= r_res_idx;
            o_remainder     <= r_res_rem;
            o_status        <= r_res_status;
        end
    end

    // control state: count, tolerance and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_tol       <= TOL_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_tol <= i_cfg_data;
            end
            if (i_cmd.simple && r_func == FUNC_CLEAR) begin
                r_count <= '0;
            end else if (n_wr_en) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_stat.is_locate = (r_func == FUNC_LOCATE);
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.search_go = (r_lo < r_hi);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

endmodule

[design/arc_length_segment_locator_core.sv]
// Top level: arc-length segment locator, controller plus datapath.
// Keeps a table of up to 256 running sums of Q16.16 segment lengths in a
// single-port memory with a registered read. A clear item empties the table
// and an append item adds one sum unless the table is full, saturating at
// 2^40 - 1; both go from decode straight to the output register. A locate
// item clamps its Q24.16 position to [0, total] (treating anything nearer
// than the configured tolerance as on the end), binary-searches for the
// first sum not below it and reports that index together with position
// minus the preceding sum, saturated to 41 bits. Each search probe reads
// the sum at the window midpoint and then narrows the window on it; after
// the search the block clamps the index while reading the preceding sum,
// waits on that read, subtracts and hands off the result. The single
// memory read port paces the search, and a stalled result sink holds the
// result back. One item is in work at a time; a new item is taken as soon
// as the previous result sits in the output register, even if the sink has
// not yet collected it. The configuration channel is always ready; write
// it only while the block is idle.
module arc_length_segment_locator_core
    import alsl_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    alsl_item_if.sink     i_item,
    alsl_result_if.source o_result,
    alsl_cfg_if.sink      i_cfg
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_item.ready = w_in_ready;
    assign i_cfg.ready  = 1'b1;

    // sequence each item through decode, search and hand-off
    alsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // hold the sums, the search window and the output register
    alsl_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_func           (i_item.func),
        .i_segment_length (i_item.segment_length),
        .i_position       (i_item.position),
        .i_cfg_write      (i_cfg.valid),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (o_result.valid),
        .o_segment_index  (o_result.segment_index),
        .o_remainder      (o_result.remainder),
        .o_status         (o_result.status)
    );

endmodule

[test/tb.sv]
// Testbench: randomised item traffic against a built-in running-sum table predictor.
module tb;
    import alsl_pkg::*;

    localparam logic [CODE_W-1:0] FUNC_UNUSED = 2'd3;
    localparam longint SUM_CEIL   = (longint'(1) << SUM_W) - 1;
    localparam longint REM_HI     = (longint'(1) << (REM_W - 1)) - 1;
    localparam longint REM_LO     = -(longint'(1) << (REM_W - 1));
    localparam int     PHASE_SPAN = 430;
    localparam int     DRAIN_CAP  = 10000;

    typedef logic signed [POS_W-1:0] t_pos;

    typedef struct packed {
        logic [CODE_W-1:0]       func;
        logic [LEN_W-1:0]        segment_length;
        logic signed [POS_W-1:0] position;
    } t_seg_item;

    typedef struct packed {
        logic [SIDX_W-1:0]       segment_index;
        logic signed [REM_W-1:0] remainder;
        logic [CODE_W-1:0]       status;
    } t_seg_result;

    // Shadow copy of the sum table and tolerance; predicts each answer on acceptance.
    class segment_table_checker;
        logic [SUM_W-1:0] sums [MAX_SEGMENTS];
        int               count      = 0;
        logic [TOL_W-1:0] tol        = TOL_W'(1);
        t_seg_result      awaited[$];
        int               faults     = 0;
        int               checked    = 0;
        int               locates    = 0;
        int               full_hits  = 0;
        int               empty_hits = 0;

        function longint sum_at(int k);
            return longint'({24'd0, sums[k]});
        endfunction

        function int entries();
            return count;
        endfunction

        function longint tol_now();
            return longint'({48'd0, tol});
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void set_tolerance(logic [TOL_W-1:0] v);
            tol = v;
        endfunction

        function void take_item(t_seg_item it);
            t_seg_result r;
            longint      s, total, t, key, diff, rem, sum;
            int          lo, hi, mid;
            r = '0;
            case (it.func)
                FUNC_CLEAR: count = 0;
                FUNC_APPEND: begin
                    if (count >= MAX_SEGMENTS) begin
                        r.status = STAT_FULL;
                        full_hits++;
                    end else begin
                        sum = (count > 0) ? sum_at(count - 1) : 0;
                        sum = sum + longint'({32'd0, it.segment_length});
                        if (sum > SUM_CEIL) sum = SUM_CEIL;
                        sums[count] = sum[SUM_W-1:0];
                        count++;
                    end
                end
                FUNC_LOCATE: begin
                    locates++;
                    if (count == 0) begin
                        r.status = STAT_EMPTY;
                        empty_hits++;
                    end else begin
                        s     = longint'(it.position);
                        total = sum_at(count - 1);
                        t     = tol_now();
                        diff  = s - total;
                        if (diff < 0) diff = -diff;
                        // clamp a copy for the search; the remainder uses the raw position
                        if (s < 0 || s < t)
                            key = 0;
                        else if (s > total || diff < t)
                            key = total;
                        else
                            key = s;
                        // lower bound: first sum not below the key
                        lo = 0;
                        hi = count;
                        while (lo < hi) begin
                            mid = lo + (hi - lo) / 2;
                            if (sum_at(mid) < key)
                                lo = mid + 1;
                            else
                                hi = mid;
                        end
                        if (lo >= count) lo = count - 1;
                        rem = (lo == 0) ? s : s - sum_at(lo - 1);
                        if (rem > REM_HI) rem = REM_HI;
                        if (rem < REM_LO) rem = REM_LO;
                        r.segment_index = lo[SIDX_W-1:0];
                        r.remainder     = rem[REM_W-1:0];
                    end
                end
                default: ;
            endcase
            awaited.push_back(r);
        endfunction

        function void check_result(t_seg_result got);
            t_seg_result want;
            if (awaited.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: unexpected result idx %0d rem %0d status %0d",
                             got.segment_index, got.remainder, got.status);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.segment_index !== want.segment_index || got.remainder !== want.remainder
                || got.status !== want.status) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch %0d: expected idx %0d rem %0d status %0d,",
                             checked, want.segment_index, want.remainder, want.status,
                             " got idx %0d rem %0d status %0d",
                             got.segment_index, got.remainder, got.status);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    alsl_item_if   item_bus ();
    alsl_result_if res_bus ();
    alsl_cfg_if    cfg_bus ();

    arc_length_segment_locator_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (res_bus),
        .i_cfg    (cfg_bus)
    );

    segment_table_checker sb;
    bit                   steady_flow = 1'b0;
    int                   items_sent  = 0;
    logic [TOL_W-1:0]     tol_seen [5];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Present one item from the falling edge and hold it until the block takes it.
    task automatic send_item(logic [CODE_W-1:0] func, logic [LEN_W-1:0] len, t_pos pos);
        t_seg_item it;
        it = '{func, len, pos};
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(0, 99) < 15) begin
            item_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        item_bus.valid          = 1'b1;
        item_bus.func           = func;
        item_bus.segment_length = len;
        item_bus.position       = pos;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        sb.take_item(it);
        items_sent++;
    endtask

    // Stop sending and wait until every awaited result has been collected.
    task automatic hold_off();
        @(negedge i_clk);
        item_bus.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] v);
        hold_off();
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.data  = v;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        sb.set_tolerance(v);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    function automatic logic [LEN_W-1:0] any_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return '0;
        if (roll < 15) return '1;
        if (roll < 25) return $urandom;
        return $urandom_range(1, 32'h0003_0000);
    endfunction

    // Mostly positions near joints and ends of the current table, some anywhere.
    function automatic t_pos pick_position();
        longint total, span, p;
        int     n, k, roll;
        n     = sb.entries();
        total = (n > 0) ? sb.sum_at(n - 1) : 0;
        span  = 2 * sb.tol_now() + 4;
        roll  = $urandom_range(0, 99);
        if (n == 0 || roll < 12) begin
            p = {$urandom, $urandom};
        end else if (roll < 40) begin
            k = $urandom_range(0, n - 1);
            p = sb.sum_at(k);
        end else if (roll < 50) begin
            k = $urandom_range(0, n - 1);
            p = sb.sum_at(k) + longint'($urandom_range(0, 4)) - 2;
        end else if (roll < 75) begin
            p = ({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff) % (total + 1);
        end else if (roll < 88) begin
            p = longint'($urandom_range(0, int'(2 * span))) - span;
        end else begin
            p = total + longint'($urandom_range(0, int'(2 * span))) - span;
        end
        return t_pos'(p);
    endfunction

    // Result side: stall at random from the falling edge, collect at the rising edge.
    initial begin
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_bus.ready = steady_flow || ($urandom_range(0, 99) >= 15);
            @(posedge i_clk);
            if (i_rst_n && res_bus.valid && res_bus.ready)
                sb.check_result('{res_bus.segment_index, res_bus.remainder, res_bus.status});
        end
    end

    initial begin
        #5_000_000;
        $display("tb: timeout");
        $display("tb: failure");
        $finish;
    end

    initial begin
        int               phase, phase_start, n, m, drain;
        bit               fill_due;
        logic [TOL_W-1:0] tol_pick;

        sb                      = new;
        i_rst_n                 = 1'b0;
        item_bus.valid          = 1'b0;
        item_bus.func           = FUNC_CLEAR;
        item_bus.segment_length = '0;
        item_bus.position       = '0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.data            = '0;
        tol_seen[0]             = TOL_W'(1);
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset tolerance: empty table, unused code, joints, extremes.
        send_item(FUNC_LOCATE, '0, '0);
        send_item(FUNC_UNUSED, '1, '1);
        send_item(FUNC_APPEND, '0, '0);
        send_item(FUNC_APPEND, '1, '0);
        send_item(FUNC_APPEND, 32'h0001_0000, '0);
        send_item(FUNC_APPEND, '0, '0);
        send_item(FUNC_APPEND, 32'h0000_8000, '0);
        send_item(FUNC_LOCATE, '0, {1'b1, {(POS_W-1){1'b0}}});
        send_item(FUNC_LOCATE, '0, {1'b0, {(POS_W-1){1'b1}}});
        send_item(FUNC_LOCATE, '0, '0);
        send_item(FUNC_LOCATE, '0, t_pos'(sb.sum_at(1)));
        send_item(FUNC_LOCATE, '0, t_pos'(sb.sum_at(2)));
        send_item(FUNC_LOCATE, '0, t_pos'(sb.sum_at(1) + 1));
        send_item(FUNC_LOCATE, '0, t_pos'(sb.sum_at(4)));
        send_item(FUNC_LOCATE, '0, t_pos'(sb.sum_at(4) - 1));
        send_item(FUNC_LOCATE, '0, t_pos'(sb.sum_at(4) + 5));
        send_item(FUNC_LOCATE, '0, -40'sd1);
        send_item(FUNC_LOCATE, '0, 40'sd1);
        send_item(FUNC_CLEAR, $urandom, pick_position());
        send_item(FUNC_LOCATE, $urandom, 40'sd7);
        send_item(FUNC_APPEND, '1, '0);
        send_item(FUNC_LOCATE, '0, 40'sh00_FFFF_FFFF);

        // Random phases, each at its own tolerance; phase 2 starts with no idling at all.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       tol_pick = TOL_W'($urandom_range(2, 65534));
                1:       tol_pick = '0;
                2:       tol_pick = '1;
                default: tol_pick = TOL_W'($urandom_range(0, 64));
            endcase
            write_tolerance(tol_pick);
            tol_seen[phase + 1] = tol_pick;
            fill_due    = (phase == 1 || phase == 3);
            steady_flow = (phase == 2);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_SPAN) begin
                if (phase == 2 && items_sent - phase_start >= 250) steady_flow = 1'b0;
                m = $urandom_range(0, 99);
                if (m < 75) begin
                    // well-formed: fresh table, appends, then locates against it
                    n        = fill_due ? MAX_SEGMENTS + 3 : $urandom_range(1, 24);
                    fill_due = 1'b0;
                    send_item(FUNC_CLEAR, $urandom, pick_position());
                    repeat (n) send_item(FUNC_APPEND, any_length(), pick_position());
                    repeat ($urandom_range(1, 20))
                        send_item(FUNC_LOCATE, $urandom, pick_position());
                end else if (m < 88) begin
                    // extend or query whatever table is there
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 2) == 0)
                            send_item(FUNC_APPEND, any_length(), pick_position());
                        else
                            send_item(FUNC_LOCATE, $urandom, pick_position());
                    end
                end else begin
                    // noise: any code, any fields
                    repeat ($urandom_range(1, 4))
                        send_item(CODE_W'($urandom_range(0, 3)), $urandom,
                                  t_pos'({$urandom, $urandom}));
                end
                if ($urandom_range(0, 9) == 0) hold_off();
            end
        end
        steady_flow = 1'b0;

        // Drain, with a bound, then allow a full-table search worth of quiet cycles.
        @(negedge i_clk);
        item_bus.valid = 1'b0;
        drain = 0;
        while (sb.pending() != 0 && drain < DRAIN_CAP) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (30) @(posedge i_clk);
        if (sb.pending() != 0)
            $display("tb: %0d expected results never arrived", sb.pending());

        $display("tb: %0d items sent, %0d results checked, %0d locates (%0d on empty table)",
                 items_sent, sb.checked, sb.locates, sb.empty_hits);
        $display("tb: %0d appends to a full table, tolerances %0d %0d %0d %0d %0d",
                 sb.full_hits, tol_seen[0], tol_seen[1], tol_seen[2], tol_seen[3], tol_seen[4]);
        if (sb.faults == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches", sb.faults);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
